FILE: rtl/aqi_pkg.sv
package aqi_pkg;

	localparam int RAW_W    = 16;   // reading width
	localparam int PT_W     = 8;    // breakpoint width (whole ug/m3)
	localparam int SEGW_W   = 7;    // segment width in ug/m3
	localparam int NUM_W    = 22;   // 50*d + width<<F
	localparam int T_W      = 21;   // numerator after the power-of-two shift
	localparam int RECIP_W  = 29;   // ceil(2^32 / width)
	localparam int RECIP_SH = 32;
	localparam int PROD_W   = T_W + RECIP_W;
	localparam int Q_W      = 17;   // quotient of the segment division
	localparam int SUB_W    = 18;   // sub-index, integer
	localparam int IDX_W    = 11;
	localparam int BAND_W   = 3;
	localparam int BASE_W   = 7;

	localparam logic [IDX_W-1:0] INDEX_MAX = 11'd2047;
	localparam int BAND_STEP = 25;
	localparam logic [NUM_W-1:0] SLOPE2 = 22'd50;   // twice the per-segment index step

	typedef enum logic [BAND_W-1:0] {
		BAND_VERY_GOOD  = 3'd0,
		BAND_GOOD       = 3'd1,
		BAND_MODERATE   = 3'd2,
		BAND_SUFFICIENT = 3'd3,
		BAND_POOR       = 3'd4
	} aqi_band_t;

	// Breakpoints, segment widths and exact reciprocals of one pollutant.
	typedef struct packed {
		logic [4:0][PT_W-1:0]    pts;
		logic [3:0][SEGW_W-1:0]  width;
		logic [3:0][RECIP_W-1:0] recip;
	} aqi_table_t;

	// Stage advance strobes from the top-level flow control.
	typedef struct packed {
		logic s2;
		logic s3;
	} aqi_adv_t;

	localparam aqi_table_t FINE_TABLE = '{
		pts:   {8'd110, 8'd55, 8'd30, 8'd15, 8'd0},
		width: {7'd55, 7'd25, 7'd15, 7'd15},
		recip: {29'd78090315, 29'd171798692, 29'd286331154, 29'd286331154}
	};

	localparam aqi_table_t COARSE_TABLE = '{
		pts:   {8'd180, 8'd90, 8'd50, 8'd25, 8'd0},
		width: {7'd90, 7'd40, 7'd25, 7'd25},
		recip: {29'd47721859, 29'd107374183, 29'd171798692, 29'd171798692}
	};

	// Index at the lower end of each segment.
	localparam logic [3:0][BASE_W-1:0] SEG_BASE = {7'd75, 7'd50, 7'd25, 7'd0};

	function automatic aqi_band_t band_of(input logic [IDX_W-1:0] idx);
		aqi_band_t b;
		if (idx <= IDX_W'(BAND_STEP)) begin
			b = BAND_VERY_GOOD;
		end else if (idx <= IDX_W'(2 * BAND_STEP)) begin
			b = BAND_GOOD;
		end else if (idx <= IDX_W'(3 * BAND_STEP)) begin
			b = BAND_MODERATE;
		end else if (idx <= IDX_W'(4 * BAND_STEP)) begin
			b = BAND_SUFFICIENT;
		end else begin
			b = BAND_POOR;
		end
		return b;
	endfunction

endpackage

FILE: rtl/aqi_in_if.sv
interface aqi_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] fine_dust;
	logic        fine_valid;
	logic [15:0] coarse_dust;
	logic        coarse_valid;

	modport source (output valid, output fine_dust, output fine_valid,
		output coarse_dust, output coarse_valid, input ready);
	modport sink (input valid, input fine_dust, input fine_valid,
		input coarse_dust, input coarse_valid, output ready);
endinterface

FILE: rtl/aqi_out_if.sv
interface aqi_out_if;
	logic        valid;
	logic        ready;
	logic        available;
	logic [10:0] quality_index;
	logic [2:0]  quality_band;

	modport source (output valid, output available, output quality_index,
		output quality_band, input ready);
	modport sink (input valid, input available, input quality_index,
		input quality_band, output ready);
endinterface

FILE: rtl/air_quality_index_from_pm.sv
// Particulate air quality index (CAQI style).
//
// Channels: sample (sink) carries one PM2.5 and one PM10 reading, each with
// its own present flag; result (source) carries available, quality_index and
// quality_band. Both are valid/ready; a transaction completes on a rising
// edge with valid and ready high.
//
// Pipeline: a taken sample passes the input register, segment select,
// reciprocal multiply and result register in order; result.valid rises when
// it reaches the result register. Throughput: one transaction per cycle while
// result.ready is high, set by the four-stage pipeline; the single
// 21x29 multiplier per pollutant sits alone between two registers.
//
// Stall: each stage advances when it is empty or the stage after it moves,
// so bubbles close up while result.ready is low and sample.ready stays high
// until all four stages hold an item. A stalled result holds its payload.
//
// Reset: arst_n clears all stage valid bits; result.valid is low and
// sample.ready is high right after reset.
module air_quality_index_from_pm #(
	parameter int FRAC_BITS = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	aqi_in_if.sink    sample,
	aqi_out_if.source result
);

	// stage valid bits
	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;
	aqi_pkg::aqi_adv_t adv;

	// input register
	logic [aqi_pkg::RAW_W-1:0] fine_s1, coarse_s1;
	logic                      fine_ok_s1, coarse_ok_s1;
	logic                      avail_s2, avail_s3;

	logic [aqi_pkg::SUB_W-1:0] fine_sub_s3, coarse_sub_s3;
	logic [aqi_pkg::IDX_W-1:0] index_c;
	aqi_pkg::aqi_band_t        band_c;

	// output register
	logic                      avail_q;
	logic [aqi_pkg::IDX_W-1:0] index_q;
	aqi_pkg::aqi_band_t        band_q;

	// backpressure runs from the output back to the input
	assign rdy4 = !v4_q || result.ready;
	assign rdy3 = !v3_q || rdy4;
	assign rdy2 = !v2_q || rdy3;
	assign rdy1 = !v1_q || rdy2;
	assign adv  = '{s2: rdy2, s3: rdy3};

	assign sample.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= sample.valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			fine_s1      <= sample.fine_dust;
			fine_ok_s1   <= sample.fine_valid;
			coarse_s1    <= sample.coarse_dust;
			coarse_ok_s1 <= sample.coarse_valid;
		end
		if (rdy2) avail_s2 <= fine_ok_s1 || coarse_ok_s1;
		if (rdy3) avail_s3 <= avail_s2;
	end

	// an absent reading yields sub-index zero, so both absent gives index 0, band 0
	aqi_sub #(.FRAC_BITS(FRAC_BITS)) u_fine (
		.clk    (clk),
		.adv    (adv),
		.tbl    (aqi_pkg::FINE_TABLE),
		.raw_s1 (fine_s1),
		.ok_s1  (fine_ok_s1),
		.sub_s3 (fine_sub_s3)
	);

	aqi_sub #(.FRAC_BITS(FRAC_BITS)) u_coarse (
		.clk    (clk),
		.adv    (adv),
		.tbl    (aqi_pkg::COARSE_TABLE),
		.raw_s1 (coarse_s1),
		.ok_s1  (coarse_ok_s1),
		.sub_s3 (coarse_sub_s3)
	);

	aqi_merge u_merge (
		.fine_sub      (fine_sub_s3),
		.coarse_sub    (coarse_sub_s3),
		.quality_index (index_c),
		.quality_band  (band_c)
	);

	always_ff @(posedge clk) begin
		if (rdy4) begin
			avail_q <= avail_s3;
			index_q <= index_c;
			band_q  <= band_c;
		end
	end

	assign result.valid         = v4_q;
	assign result.available     = avail_q;
	assign result.quality_index = index_q;
	assign result.quality_band  = band_q;

endmodule

FILE: rtl/aqi_sub.sv
// Sub-index of one pollutant: segment select, then exact division by the
// segment width through a reciprocal multiply. Two register stages.
module aqi_sub #(
	parameter int FRAC_BITS = 4
) (
	input  logic                             clk,
	input  aqi_pkg::aqi_adv_t                adv,
	input  aqi_pkg::aqi_table_t              tbl,
	input  logic [aqi_pkg::RAW_W-1:0]        raw_s1,
	input  logic                             ok_s1,
	output logic [aqi_pkg::SUB_W-1:0]        sub_s3
);

	localparam int SH = FRAC_BITS + 1;

	logic [aqi_pkg::RAW_W-1:0]  bp1, bp2, bp3, lo, d;
	logic [1:0]                 seg;
	logic [aqi_pkg::NUM_W-1:0]  num;
	logic [aqi_pkg::T_W-1:0]    t;

	logic [aqi_pkg::T_W-1:0]    t_s2;
	logic [1:0]                 seg_s2;
	logic                       ok_s2;

	logic [aqi_pkg::PROD_W-1:0] prod;
	logic [aqi_pkg::Q_W-1:0]    q;

	assign bp1 = aqi_pkg::RAW_W'(tbl.pts[1]) << FRAC_BITS;
	assign bp2 = aqi_pkg::RAW_W'(tbl.pts[2]) << FRAC_BITS;
	assign bp3 = aqi_pkg::RAW_W'(tbl.pts[3]) << FRAC_BITS;

	// a reading on a breakpoint takes the lower segment; top segment extrapolates
	always_comb begin
		priority if (raw_s1 <= bp1) begin
			seg = 2'd0;
		end else if (raw_s1 <= bp2) begin
			seg = 2'd1;
		end else if (raw_s1 <= bp3) begin
			seg = 2'd2;
		end else begin
			seg = 2'd3;
		end
	end

	assign lo  = aqi_pkg::RAW_W'(tbl.pts[{1'b0, seg}]) << FRAC_BITS;
	assign d   = raw_s1 - lo;
	// round half up of 25*d/(w*2^F): floor((50d + w*2^F) / (2w*2^F))
	assign num = aqi_pkg::NUM_W'(d) * aqi_pkg::SLOPE2
		+ (aqi_pkg::NUM_W'(tbl.width[seg]) << FRAC_BITS);
	assign t   = aqi_pkg::T_W'(num >> SH);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			t_s2   <= t;
			seg_s2 <= seg;
			ok_s2  <= ok_s1;
		end
	end

	// reciprocal is exact for every t below 2^21
	assign prod = aqi_pkg::PROD_W'(t_s2) * aqi_pkg::PROD_W'(tbl.recip[seg_s2]);
	assign q    = prod[aqi_pkg::RECIP_SH +: aqi_pkg::Q_W];

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sub_s3 <= ok_s2
				? aqi_pkg::SUB_W'(aqi_pkg::SEG_BASE[seg_s2]) + aqi_pkg::SUB_W'(q)
				: '0;
		end
	end

endmodule

FILE: rtl/aqi_merge.sv
// Larger sub-index, saturation, band.
module aqi_merge (
	input  logic [aqi_pkg::SUB_W-1:0] fine_sub,
	input  logic [aqi_pkg::SUB_W-1:0] coarse_sub,
	output logic [aqi_pkg::IDX_W-1:0] quality_index,
	output aqi_pkg::aqi_band_t        quality_band
);

	logic [aqi_pkg::SUB_W-1:0] top;

	assign top = (fine_sub > coarse_sub) ? fine_sub : coarse_sub;
	assign quality_index = (top > aqi_pkg::SUB_W'(aqi_pkg::INDEX_MAX))
		? aqi_pkg::INDEX_MAX : top[aqi_pkg::IDX_W-1:0];
	assign quality_band = aqi_pkg::band_of(quality_index);

endmodule

FILE: rtl/aqi_checker.sv
module aqi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_ready,
	input logic        r_valid,
	input logic        r_ready,
	input logic        r_available,
	input logic [10:0] r_index,
	input logic [2:0]  r_band
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_ready |=> r_valid && $stable(r_available)
			&& $stable(r_index) && $stable(r_band))
		else $error("stalled result changed");

	// with no result waiting the pipeline always has room
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		!r_valid |-> s_ready)
		else $error("input stalled with empty output");

	a_unavail: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid && !r_available |-> r_index == 11'd0
			&& r_band == aqi_pkg::BAND_VERY_GOOD)
		else $error("unavailable result not zero");

	a_band: assert property (@(posedge clk) disable iff (!arst_n)
		r_valid |->
			(r_index <= 11'd25 && r_band == aqi_pkg::BAND_VERY_GOOD)
			|| (r_index > 11'd25 && r_index <= 11'd50 && r_band == aqi_pkg::BAND_GOOD)
			|| (r_index > 11'd50 && r_index <= 11'd75 && r_band == aqi_pkg::BAND_MODERATE)
			|| (r_index > 11'd75 && r_index <= 11'd100
				&& r_band == aqi_pkg::BAND_SUFFICIENT)
			|| (r_index > 11'd100 && r_band == aqi_pkg::BAND_POOR))
		else $error("band does not match index");

endmodule

bind air_quality_index_from_pm aqi_checker u_aqi_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.s_ready     (sample.ready),
	.r_valid     (result.valid),
	.r_ready     (result.ready),
	.r_available (result.available),
	.r_index     (result.quality_index),
	.r_band      (result.quality_band)
);
